// ===== design/size_class_chunk_allocator_defines.svh =====
// Assertion macros for the chunk allocator
`ifndef SIZE_CLASS_CHUNK_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_CHUNK_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCCA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SCCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SCCA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCCA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/scca_pkg.sv =====
// Types, constants and helpers shared by the chunk allocator modules
package scca_pkg;
   localparam int MAX_CHUNKS_DEF = 64;
   localparam int HEAP_BYTES_DEF = 65536;
   localparam logic [9:0] MAX_REQUEST = 10'd512;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_NEW   = 3'd1;
   localparam logic [2:0] ST_BADSZ = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_NOTAL = 3'd4;

   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_DEALLOC = 1'b1;

   typedef struct packed {
      logic       func;
      logic [9:0] request_size;
      logic [5:0] release_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  chunk_id;
      logic [15:0] chunk_base;
      logic [9:0]  chunk_capacity;
   } rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      logic       func;
      logic       bad_size;
      logic [2:0] size_class;
      logic [9:0] request_size;
      logic [5:0] release_id;
   } cmd_type;

   // Class bytes: 32 << class, capped at 512 for class 4 and above
   function automatic logic [9:0] class_bytes(input logic [2:0] c);
      case (c)
         3'd0: class_bytes = 10'd32;
         3'd1: class_bytes = 10'd64;
         3'd2: class_bytes = 10'd128;
         3'd3: class_bytes = 10'd256;
         default: class_bytes = 10'd512;
      endcase
   endfunction

   // Smallest class that holds the size
   function automatic logic [2:0] size_to_class(input logic [9:0] s);
      if (s <= 10'd32) size_to_class = 3'd0;
      else if (s <= 10'd64) size_to_class = 3'd1;
      else if (s <= 10'd128) size_to_class = 3'd2;
      else if (s <= 10'd256) size_to_class = 3'd3;
      else size_to_class = 3'd4;
   endfunction
endpackage

// ===== design/size_class_chunk_allocator.sv =====
// Top level of the size-class chunk allocator
//  channel | ports                         | handshake
//  request | start/busy, req_data          | start && !busy
//  result  | rsp_valid, rsp_data           | strobe, one cycle
//  csr     | csr_valid/csr_ready, csr_data | valid && ready
// Allocate is popped, scans the table through the registered read of the table RAM,
// then decides and strobes its result.
// Deallocate and bad size are popped, then read or decide, then strobe.
// Synchronous reset clears the valid and busy bits, counters and queue at once.
// A two-entry queue takes requests while the back end scans; busy rises when full.
// The result is a one-cycle strobe; the receiver cannot stall it.
`include "size_class_chunk_allocator_defines.svh"
module size_class_chunk_allocator #(
   parameter int MAX_CHUNKS = scca_pkg::MAX_CHUNKS_DEF,
   parameter int HEAP_BYTES = scca_pkg::HEAP_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  scca_pkg::req_type req_data,
   output logic              rsp_valid,
   output scca_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   logic fit_mode_ff;
   logic cmd_valid, cmd_pop, idle;
   scca_pkg::cmd_type cmd_data;

   // Hold the fit mode register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) fit_mode_ff <= 1'b0;
      else if (csr_valid && csr_ready) fit_mode_ff <= csr_data;
   end

   scca_front u_front (
      .clock, .reset, .start, .busy, .req_data, .cmd_valid, .cmd_data, .cmd_pop
   );

   scca_back #(.MAX_CHUNKS(MAX_CHUNKS), .HEAP_BYTES(HEAP_BYTES)) u_back (
      .clock, .reset, .fit_mode(fit_mode_ff), .cmd_valid, .cmd_data, .cmd_pop,
      .rsp_valid, .rsp_data, .idle
   );

   `SCCA_ASSERT_NEXT(a_pop_one, clock, reset, cmd_pop, !cmd_pop)
   `SCCA_ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   `SCCA_ASSERT_IMPL(a_idle_quiet, clock, reset, idle, !cmd_valid)
endmodule

// ===== design/scca_ram.sv =====
// Generic single-port-write, single-read RAM with registered read
module scca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== design/scca_front.sv =====
// Front end: accept requests, classify, hold them in a two-entry queue
module scca_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  scca_pkg::req_type req_data,
   output logic              cmd_valid,
   output scca_pkg::cmd_type cmd_data,
   input  logic              cmd_pop
);
   scca_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   scca_pkg::cmd_type new_cmd;
   logic push;

   // Classify the incoming request
   always_comb begin
      new_cmd.func = req_data.func;
      new_cmd.bad_size = (req_data.request_size == 10'd0) ||
                         (req_data.request_size > scca_pkg::MAX_REQUEST);
      new_cmd.size_class = scca_pkg::size_to_class(req_data.request_size);
      new_cmd.request_size = req_data.request_size;
      new_cmd.release_id = req_data.release_id;
   end

   assign busy = cnt_ff[1];
   assign push = start && !busy;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd_data = q_ff[rd_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};

   // Advance queue pointers and hold entries
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (cmd_pop) rd_ff <= !rd_ff;
      end
      if (push) q_ff[wr_ff] <= new_cmd;
   end
endmodule

// ===== design/scca_back.sv =====
// Back end: scan the chunk table, pick or carve a chunk or free one, write back
module scca_back #(
   parameter int MAX_CHUNKS = scca_pkg::MAX_CHUNKS_DEF,
   parameter int HEAP_BYTES = scca_pkg::HEAP_BYTES_DEF,
   localparam int IW = $clog2(MAX_CHUNKS),
   localparam int CW = $clog2(MAX_CHUNKS + 1),
   localparam int HW = $clog2(HEAP_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fit_mode,
   input  logic              cmd_valid,
   input  scca_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   output scca_pkg::rsp_type rsp_data,
   output logic              idle
);
   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_DREAD, S_DONE
   } state_type;

   // entry: class, base, stamp
   localparam int EW = 3 + 16 + 32;

   state_type state_ff;
   scca_pkg::cmd_type cmd_ff;
   logic [MAX_CHUNKS-1:0] valid_ff, busy_ff;
   logic [CW-1:0] count_ff;
   logic [HW:0]   top_ff;
   logic [31:0]   stamp_ff;
   logic [IW:0]   idx_ff;      // read address issued
   logic          rv_ff;       // read data valid for idx-1
   logic [IW-1:0] ridx_ff;
   logic          have_ff;
   logic [IW-1:0] pick_ff;
   logic [2:0]    pcls_ff;
   logic [31:0]   page_ff;
   logic [15:0]   pbase_ff;
   logic          rsp_valid_ff;
   scca_pkg::rsp_type rsp_ff;

   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [2:0]    e_cls;
   logic [15:0]   e_base;
   logic [31:0]   e_stamp, e_age;
   logic          fits, better;

   scca_ram #(.WIDTH(EW), .DEPTH(MAX_CHUNKS)) u_table (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   assign e_cls = (rd_data[EW-1 -: 3] > 3'd4) ? 3'd4 : rd_data[EW-1 -: 3];
   assign e_base = rd_data[47:32];
   assign e_stamp = rd_data[31:0];
   assign e_age = stamp_ff - e_stamp;
   assign fits = rv_ff && valid_ff[ridx_ff] && !busy_ff[ridx_ff] &&
                 (scca_pkg::class_bytes(e_cls) >= cmd_ff.request_size);
   always_comb begin
      if (!have_ff) better = 1'b1;
      else if (fit_mode) better = (e_cls < pcls_ff) ||
                                  (e_cls == pcls_ff && e_age > page_ff);
      else better = e_age > page_ff;
   end

   assign rd_addr = (state_ff == S_IDLE) ?
                    (cmd_data.release_id[IW-1:0]) : idx_ff[IW-1:0];
   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign idle = (state_ff == S_IDLE) && !cmd_valid;

   // Table writes: new chunk or dealloc stamp
   always_comb begin
      wr_en = 1'b0;
      wr_addr = count_ff[IW-1:0];
      wr_data = {scca_pkg::size_to_class(cmd_ff.request_size), top_ff[15:0], 32'd0};
      if (state_ff == S_DECIDE && !have_ff && !cmd_ff.bad_size &&
          count_ff < CW'(MAX_CHUNKS) &&
          top_ff + (HW+1)'(scca_pkg::class_bytes(cmd_ff.size_class)) <=
          (HW+1)'(HEAP_BYTES)) begin
         wr_en = 1'b1;
      end else if (state_ff == S_DREAD && valid_ff[ridx_ff] && busy_ff[ridx_ff]) begin
         wr_en = 1'b1;
         wr_addr = ridx_ff;
         wr_data = {rd_data[EW-1 -: 19], stamp_ff};
      end
   end

   // Sequencer: scan, decide, respond
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         busy_ff <= '0;
         count_ff <= '0;
         top_ff <= '0;
         stamp_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd_data;
                  have_ff <= 1'b0;
                  idx_ff <= '0;
                  rv_ff <= 1'b0;
                  ridx_ff <= cmd_data.release_id[IW-1:0];
                  if (cmd_data.func == scca_pkg::FUNC_DEALLOC) begin
                     rv_ff <= 1'b1;
                     state_ff <= S_DREAD;
                  end else if (cmd_data.bad_size) begin
                     state_ff <= S_DECIDE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (fits && better) begin
                  have_ff <= 1'b1;
                  pick_ff <= ridx_ff;
                  pcls_ff <= e_cls;
                  page_ff <= e_age;
                  pbase_ff <= e_base;
               end
               rv_ff <= !idx_ff[IW] && (idx_ff < (IW+1)'(MAX_CHUNKS));
               ridx_ff <= idx_ff[IW-1:0];
               if (idx_ff < (IW+1)'(MAX_CHUNKS)) idx_ff <= idx_ff + 1'b1;
               if (!rv_ff && idx_ff >= (IW+1)'(MAX_CHUNKS)) state_ff <= S_DECIDE;
               else if (rv_ff && idx_ff >= (IW+1)'(MAX_CHUNKS) &&
                        ridx_ff == IW'(MAX_CHUNKS - 1)) begin
                  rv_ff <= 1'b0;
               end
            end
            S_DECIDE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_DONE;
               if (cmd_ff.bad_size) begin
                  rsp_ff <= '{scca_pkg::ST_BADSZ, 6'd0, 16'd0, 10'd0};
               end else if (have_ff) begin
                  busy_ff[pick_ff] <= 1'b1;
                  rsp_ff <= '{scca_pkg::ST_OK, 6'(pick_ff), pbase_ff,
                              scca_pkg::class_bytes(pcls_ff)};
               end else if (wr_en) begin
                  valid_ff[count_ff[IW-1:0]] <= 1'b1;
                  busy_ff[count_ff[IW-1:0]] <= 1'b1;
                  count_ff <= count_ff + 1'b1;
                  top_ff <= top_ff + (HW+1)'(scca_pkg::class_bytes(cmd_ff.size_class));
                  rsp_ff <= '{scca_pkg::ST_NEW, 6'(count_ff), top_ff[15:0],
                              scca_pkg::class_bytes(cmd_ff.size_class)};
               end else begin
                  rsp_ff <= '{scca_pkg::ST_FULL, 6'd0, 16'd0, 10'd0};
               end
            end
            S_DREAD: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_DONE;
               rv_ff <= 1'b0;
               if ({1'b0, cmd_ff.release_id} < 7'(MAX_CHUNKS) &&
                   valid_ff[ridx_ff] && busy_ff[ridx_ff]) begin
                  busy_ff[ridx_ff] <= 1'b0;
                  stamp_ff <= stamp_ff + 32'd1;
                  rsp_ff <= '{scca_pkg::ST_OK, cmd_ff.release_id, e_base,
                              scca_pkg::class_bytes(e_cls)};
               end else begin
                  rsp_ff <= '{scca_pkg::ST_NOTAL, cmd_ff.release_id, 16'd0, 10'd0};
               end
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== bench/size_class_chunk_allocator_checker.sv =====
// Checker for the chunk allocator: predicts each response and compares it
`timescale 1ns / 1ps
module size_class_chunk_allocator_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  scca_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  scca_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_data,
   output int                fail_count,
   output int                pending_count
);
   localparam int CHUNKS = scca_pkg::MAX_CHUNKS_DEF;
   localparam int HEAP = scca_pkg::HEAP_BYTES_DEF;

   // allocator shadow state
   logic          mdl_fit;
   logic          mdl_valid [CHUNKS];
   logic          mdl_busy [CHUNKS];
   logic [2:0]    mdl_class [CHUNKS];
   logic [15:0]   mdl_base [CHUNKS];
   logic [31:0]   mdl_stamp [CHUNKS];
   int unsigned   mdl_count;
   int unsigned   mdl_top;
   logic [31:0]   mdl_clock;

   scca_pkg::rsp_type expected_rsp [$];

   function automatic logic [9:0] chunk_bytes(input logic [2:0] c);
      return 10'd32 << ((c > 3'd4) ? 3'd4 : c);
   endfunction

   // work out the response to one request and advance the shadow state
   function automatic scca_pkg::rsp_type predict_request(input scca_pkg::req_type rq);
      scca_pkg::rsp_type r;
      int pick;
      logic [2:0] pick_cls, c;
      logic [31:0] pick_age, age;
      logic better;
      r = '0;
      pick = -1;
      pick_cls = '0;
      pick_age = '0;
      if (rq.func == scca_pkg::FUNC_DEALLOC) begin
         if (!mdl_valid[rq.release_id] || !mdl_busy[rq.release_id]) begin
            r.status = scca_pkg::ST_NOTAL;
            r.chunk_id = rq.release_id;
         end else begin
            mdl_busy[rq.release_id] = 1'b0;
            mdl_stamp[rq.release_id] = mdl_clock;
            mdl_clock++;
            r.status = scca_pkg::ST_OK;
            r.chunk_id = rq.release_id;
            r.chunk_base = mdl_base[rq.release_id];
            r.chunk_capacity = chunk_bytes(mdl_class[rq.release_id]);
         end
         return r;
      end
      if (rq.request_size == 10'd0 || rq.request_size > scca_pkg::MAX_REQUEST) begin
         r.status = scca_pkg::ST_BADSZ;
         return r;
      end
      // scan free chunks for the oldest-freed or the best fit
      for (int i = 0; i < CHUNKS; i++) begin
         if (mdl_valid[i] && !mdl_busy[i] && chunk_bytes(mdl_class[i]) >= rq.request_size) begin
            c = mdl_class[i];
            age = mdl_clock - mdl_stamp[i];
            if (pick < 0) better = 1'b1;
            else if (mdl_fit) better = (c < pick_cls) || (c == pick_cls && age > pick_age);
            else better = age > pick_age;
            if (better) begin
               pick = i;
               pick_cls = c;
               pick_age = age;
            end
         end
      end
      if (pick >= 0) begin
         mdl_busy[pick] = 1'b1;
         r.status = scca_pkg::ST_OK;
         r.chunk_id = 6'(pick);
         r.chunk_base = mdl_base[pick];
         r.chunk_capacity = chunk_bytes(pick_cls);
         return r;
      end
      c = 3'd0;
      while (c < 3'd4 && chunk_bytes(c) < rq.request_size) c++;
      if (mdl_count >= CHUNKS || HEAP - mdl_top < chunk_bytes(c)) begin
         r.status = scca_pkg::ST_FULL;
         return r;
      end
      mdl_valid[mdl_count] = 1'b1;
      mdl_busy[mdl_count] = 1'b1;
      mdl_class[mdl_count] = c;
      mdl_base[mdl_count] = mdl_top[15:0];
      mdl_stamp[mdl_count] = '0;
      r.status = scca_pkg::ST_NEW;
      r.chunk_id = 6'(mdl_count);
      r.chunk_base = mdl_top[15:0];
      r.chunk_capacity = chunk_bytes(c);
      mdl_count++;
      mdl_top += chunk_bytes(c);
      return r;
   endfunction

   assign pending_count = expected_rsp.size();

   always @(posedge clock) begin
      scca_pkg::rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         mdl_fit <= 1'b0;
         for (int i = 0; i < CHUNKS; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_busy[i] = 1'b0;
         end
         mdl_count = 0;
         mdl_top = 0;
         mdl_clock = '0;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         // compare a response against the oldest prediction
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("response with no request outstanding");
               errs++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_data.status);
                  errs++;
               end
               if (rsp_data.chunk_id !== want.chunk_id) begin
                  $error("chunk_id expected %0d actual %0d", want.chunk_id, rsp_data.chunk_id);
                  errs++;
               end
               if (rsp_data.chunk_base !== want.chunk_base) begin
                  $error("chunk_base expected %0d actual %0d",
                         want.chunk_base, rsp_data.chunk_base);
                  errs++;
               end
               if (rsp_data.chunk_capacity !== want.chunk_capacity) begin
                  $error("chunk_capacity expected %0d actual %0d",
                         want.chunk_capacity, rsp_data.chunk_capacity);
                  errs++;
               end
            end
         end
         // predict each accepted request
         if (start && !busy) expected_rsp = {expected_rsp, predict_request(req_data)};
         if (csr_valid && csr_ready) mdl_fit <= csr_data;
         fail_count <= fail_count + errs;
      end
   end
endmodule

// ===== bench/size_class_chunk_allocator_tb.sv =====
// Testbench top for the chunk allocator: stimulus, watchdog and verdict
`timescale 1ns / 1ps
module size_class_chunk_allocator_tb;
   localparam int STALL_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 1100;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   scca_pkg::req_type req_data;
   logic              rsp_valid;
   scca_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_data;
   int                fail_count;
   int                pending_count;
   int                idle_cycles;

   size_class_chunk_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   size_class_chunk_allocator_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: end the run when no request, response or fit-mode write is seen for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // send one request, holding start until accepted; start stays high for the next one
   task automatic send_request(input logic fn, input logic [9:0] sz, input logic [5:0] id);
      req_data <= '{func: fn, request_size: sz, release_id: id};
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // drop start, wait for all outstanding responses, then write the fit mode
   task automatic drain_and_write(input logic mode);
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_data <= mode;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_gap(input bit quiet);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   initial begin
      int pick;
      logic [9:0] sz;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: bad sizes, extremes, classes, unknown frees, both fit modes
      send_request(scca_pkg::FUNC_ALLOC, 10'd0, 6'd63);
      send_request(scca_pkg::FUNC_ALLOC, 10'd513, 6'd0);
      send_request(scca_pkg::FUNC_ALLOC, 10'd1023, 6'd0);
      send_request(scca_pkg::FUNC_DEALLOC, 10'd0, 6'd0);
      send_request(scca_pkg::FUNC_DEALLOC, 10'd1023, 6'd63);
      send_request(scca_pkg::FUNC_ALLOC, 10'd512, 6'd0);
      send_request(scca_pkg::FUNC_ALLOC, 10'd1, 6'd0);
      send_request(scca_pkg::FUNC_ALLOC, 10'd64, 6'd0);
      send_request(scca_pkg::FUNC_ALLOC, 10'd129, 6'd0);
      send_request(scca_pkg::FUNC_ALLOC, 10'd100, 6'd0);
      send_request(scca_pkg::FUNC_DEALLOC, 10'd0, 6'd0);
      send_request(scca_pkg::FUNC_DEALLOC, 10'd0, 6'd0);
      send_request(scca_pkg::FUNC_DEALLOC, 10'd0, 6'd1);
      send_request(scca_pkg::FUNC_DEALLOC, 10'd0, 6'd2);
      send_request(scca_pkg::FUNC_ALLOC, 10'd20, 6'd0);
      drain_and_write(1'b1);
      send_request(scca_pkg::FUNC_ALLOC, 10'd20, 6'd0);
      send_request(scca_pkg::FUNC_ALLOC, 10'd60, 6'd0);
      send_request(scca_pkg::FUNC_DEALLOC, 10'd0, 6'd5);
      drain_and_write(1'b0);

      // random: mostly valid allocs and frees of random chunk ids, some noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) drain_and_write(1'b1);
         if (n == 2 * RANDOM_ITEMS / 3) drain_and_write(1'b0);
         if (n == 700) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         random_gap(n > RANDOM_ITEMS - 100);
         pick = $urandom_range(0, 63);
         case ($urandom_range(0, 9))
            0: send_request(scca_pkg::FUNC_ALLOC, 10'($urandom), 6'($urandom));
            1: send_request(scca_pkg::FUNC_DEALLOC, 10'($urandom), 6'($urandom));
            2, 3, 4, 5: begin
               sz = (n < 300) ? 10'($urandom_range(1, 64)) : 10'($urandom_range(1, 512));
               send_request(scca_pkg::FUNC_ALLOC, sz, 6'($urandom));
            end
            default: send_request(scca_pkg::FUNC_DEALLOC, 10'($urandom), 6'(pick));
         endcase
      end

      // end of run: drain, settle, verdict
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
